>>> rtl/bggf_pkg.sv
// Shared constants and types for the blur / gradient gate filter.
package bggf_pkg;

	localparam int BGGF_MAX_WIDTH  = 1024;
	localparam int BGGF_MAX_HEIGHT = 1024;

	localparam int PIX_W   = 8;
	localparam int CFG_W   = 11;
	localparam int POS_W   = 10;
	localparam int COLSUM_W = 10;

	localparam int OQ_DEPTH = 4;
	localparam int OQ_PW    = $clog2(OQ_DEPTH);
	localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

	localparam int MIN_SIZE = 3;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1,
		REG_GRAD_THRESH  = 2'd2
	} cfg_reg_t;

	// one window column, index 0 is the top row
	typedef logic [2:0][PIX_W-1:0] col_t;

	// per-column partial results of one cell
	typedef struct packed {
		logic [COLSUM_W-1:0] col_sum;
		logic [PIX_W-1:0]    edge_part;
		logic [PIX_W-1:0]    mid_part;
	} cell_sum_t;

	typedef struct packed {
		logic [PIX_W-1:0] peak;
		logic             last;
		logic [POS_W-1:0] col;
		logic [POS_W-1:0] row;
		logic [PIX_W-1:0] pixel;
	} res_t;

endpackage

>>> rtl/bggf_ram.sv
// Generic single-write, single-read RAM with registered read data.
module bggf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read-first: a same-cycle write is not seen by the read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/bggf_cell.sv
// One window column cell: holds three taps, passes them left, forms partial sums.
module bggf_cell
	import bggf_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      shift_en,
	input  col_t      col_in,
	output col_t      col_out,
	output cell_sum_t sums
);

	col_t taps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			taps_q <= '0;
		end else if (shift_en) begin
			taps_q <= col_in;
		end
	end

	assign col_out = taps_q;

	// each tap is truncated on its own before the add
	always_comb begin
		sums.col_sum   = COLSUM_W'(taps_q[0]) + COLSUM_W'(taps_q[1]) + COLSUM_W'(taps_q[2]);
		sums.edge_part = PIX_W'(taps_q[0] >> 4) + PIX_W'(taps_q[1] >> 3)
			+ PIX_W'(taps_q[2] >> 4);
		sums.mid_part  = PIX_W'(taps_q[0] >> 3) + PIX_W'(taps_q[1] >> 2)
			+ PIX_W'(taps_q[2] >> 3);
	end

endmodule

>>> rtl/blur_gradient_gate_filter_core.sv
// Top level: 3x3 binomial blur gated by horizontal gradient, with frame peak.
//
// channel  dir  handshake              payload
// -------  ---  ---------------------  ------------------------------------------
// s_*      in   s_tvalid / s_tready    tdata gray_pixel, tuser frame_start
// m_*      out  m_tvalid / m_tready    tdata pixel,row,col,peak; tlast frame_last
// cfg_*    in   cfg_valid / cfg_ready  cfg_index register, cfg_data value
//
// One input word per clock while s_tready is high. On the way out a word
// passes line store read (s1), window shift into the cell row (s2), result
// into a 4-entry output queue. Line stores are two single-port-write RAMs;
// a one-entry forward register covers the same-address read after write.
// arst_n resets counters, window, peak, config and the queue; line stores
// are not cleared. s_tready drops only when the queue plus words in flight
// could fill it, so input keeps flowing while a result waits on m_tready.
module blur_gradient_gate_filter_core
	import bggf_pkg::*;
#(
	parameter int MAX_WIDTH  = BGGF_MAX_WIDTH,
	parameter int MAX_HEIGHT = BGGF_MAX_HEIGHT
) (
	input  logic             clk,
	input  logic             arst_n,
	// input pixels
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [7:0]       s_tdata,   // [7:0] gray_pixel
	input  logic             s_tuser,   // [0] frame_start
	// results
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [39:0]      m_tdata,   // [7:0] filtered_pixel, [17:8] out_row,
	                                    // [27:18] out_col, [35:28] frame_peak, rest 0
	output logic             m_tlast,   // frame_last
	// configuration writes
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);       // line store address / column counter
	localparam int RW = $clog2(MAX_HEIGHT);      // row counter
	localparam int WW = $clog2(MAX_WIDTH + 1);   // effective width
	localparam int HW = $clog2(MAX_HEIGHT + 1);  // effective height

	// reset sizes, saturated like a written value
	localparam int W_RST = (MAX_WIDTH < 640) ? MAX_WIDTH : 640;
	localparam int H_RST = (MAX_HEIGHT < 480) ? MAX_HEIGHT : 480;

	// ---------------- configuration ----------------
	logic [WW-1:0]           w_eff_q;
	logic [HW-1:0]           h_eff_q;
	logic signed [CFG_W-1:0] thr_q;
	logic [31:0]             cfg_v32;

	assign cfg_ready = 1'b1;
	assign cfg_v32   = 32'(cfg_data);

	// sizes are saturated into the legal range when written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_eff_q <= WW'(W_RST);
			h_eff_q <= HW'(H_RST);
			thr_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH: begin
					if (cfg_v32 < 32'(MIN_SIZE)) w_eff_q <= WW'(MIN_SIZE);
					else if (cfg_v32 > 32'(MAX_WIDTH)) w_eff_q <= WW'(MAX_WIDTH);
					else w_eff_q <= WW'(cfg_v32);
				end
				REG_FRAME_HEIGHT: begin
					if (cfg_v32 < 32'(MIN_SIZE)) h_eff_q <= HW'(MIN_SIZE);
					else if (cfg_v32 > 32'(MAX_HEIGHT)) h_eff_q <= HW'(MAX_HEIGHT);
					else h_eff_q <= HW'(cfg_v32);
				end
				REG_GRAD_THRESH: begin
					thr_q <= $signed(cfg_data);
				end
				default: begin
				end
			endcase
		end
	end

	// ---------------- stage 0: raster position ----------------
	logic [RW-1:0] row_q;
	logic [AW-1:0] col_q;
	logic          in_acc;
	logic [RW-1:0] r0;
	logic [AW-1:0] c0;
	logic [31:0]   r0_32, c0_32;
	logic [RW-1:0] row_nx;
	logic [AW-1:0] col_nx;
	logic          wrap0, emit0, last0;

	assign in_acc = s_tvalid && s_tready;
	assign r0     = s_tuser ? '0 : row_q;
	assign c0     = s_tuser ? '0 : col_q;
	assign r0_32  = 32'(r0);
	assign c0_32  = 32'(c0);
	assign emit0  = (r0_32 >= 32'd2) && (c0_32 >= 32'd2);
	assign last0  = (r0_32 == 32'(h_eff_q) - 32'd1) && (c0_32 == 32'(w_eff_q) - 32'd1);

	always_comb begin
		row_nx = r0;
		col_nx = AW'(c0_32 + 32'd1);
		wrap0  = 1'b0;
		if (c0_32 + 32'd1 >= 32'(w_eff_q)) begin
			col_nx = '0;
			if (r0_32 + 32'd1 >= 32'(h_eff_q)) begin
				row_nx = '0;
				wrap0  = 1'b1;
			end else begin
				row_nx = RW'(r0_32 + 32'd1);
			end
		end else if (r0_32 >= 32'(h_eff_q)) begin
			row_nx = '0;
			col_nx = '0;
			wrap0  = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (in_acc) begin
			row_q <= row_nx;
			col_q <= col_nx;
		end
	end

	// ---------------- stage 1: line store read, write back ----------------
	logic             v_s1;
	logic [PIX_W-1:0] px_s1;
	logic [AW-1:0]    addr_s1;
	logic             fs_s1, wrap_s1, emit_s1, last_s1;
	logic [POS_W-1:0] orow_s1, ocol_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			px_s1   <= s_tdata;
			addr_s1 <= c0;
			fs_s1   <= s_tuser;
			wrap_s1 <= wrap0;
			emit_s1 <= emit0;
			last_s1 <= last0;
			orow_s1 <= POS_W'(r0_32 - 32'd1);
			ocol_s1 <= POS_W'(c0_32 - 32'd1);
		end
	end

	logic [PIX_W-1:0] up_rd, mid_rd, up_eff, mid_eff;
	logic             fwd_v_q;
	logic [AW-1:0]    fwd_addr_q;
	logic [PIX_W-1:0] fwd_up_q, fwd_mid_q;
	logic             fwd_hit;

	bggf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_upper (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (mid_eff),
		.re    (in_acc),
		.raddr (c0),
		.rdata (up_rd)
	);

	bggf_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_line_middle (
		.clk   (clk),
		.we    (v_s1),
		.waddr (addr_s1),
		.wdata (px_s1),
		.re    (in_acc),
		.raddr (c0),
		.rdata (mid_rd)
	);

	// last write may land on the edge this word was read: take it from here
	assign fwd_hit = fwd_v_q && (fwd_addr_q == addr_s1);
	assign up_eff  = fwd_hit ? fwd_up_q  : up_rd;
	assign mid_eff = fwd_hit ? fwd_mid_q : mid_rd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_v_q <= 1'b0;
		end else if (v_s1) begin
			fwd_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fwd_addr_q <= addr_s1;
			fwd_up_q   <= mid_eff;
			fwd_mid_q  <= px_s1;
		end
	end

	// ---------------- window: row of three column cells ----------------
	col_t      col_new, col_r, col_c, col_l;
	cell_sum_t sum_l, sum_c, sum_r;

	assign col_new = {px_s1, mid_eff, up_eff};

	bggf_cell u_cell_right (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (v_s1),
		.col_in   (col_new),
		.col_out  (col_r),
		.sums     (sum_r)
	);

	bggf_cell u_cell_center (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (v_s1),
		.col_in   (col_r),
		.col_out  (col_c),
		.sums     (sum_c)
	);

	bggf_cell u_cell_left (
		.clk      (clk),
		.arst_n   (arst_n),
		.shift_en (v_s1),
		.col_in   (col_c),
		.col_out  (col_l),
		.sums     (sum_l)
	);

	// ---------------- stage 2: blur, gate, peak ----------------
	logic             v_s2, fs_s2, wrap_s2, emit_s2, last_s2;
	logic [POS_W-1:0] orow_s2, ocol_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			fs_s2   <= fs_s1;
			wrap_s2 <= wrap_s1;
			emit_s2 <= emit_s1;
			last_s2 <= last_s1;
			orow_s2 <= orow_s1;
			ocol_s2 <= ocol_s1;
		end
	end

	logic [PIX_W-1:0]        blur, center_px, peak_q, peak_pre, peak_new;
	logic signed [CFG_W-1:0] grad;
	res_t                    res;

	assign center_px = col_c[1];
	assign blur      = sum_l.edge_part + sum_c.mid_part + sum_r.edge_part;
	assign grad      = $signed({1'b0, sum_l.col_sum}) - $signed({1'b0, sum_r.col_sum});
	assign peak_pre  = fs_s2 ? '0 : peak_q;
	assign peak_new  = (emit_s2 && (center_px > peak_pre)) ? center_px : peak_pre;

	always_comb begin
		res.pixel = (grad > thr_q) ? blur : '0;
		res.row   = orow_s2;
		res.col   = ocol_s2;
		res.last  = last_s2;
		res.peak  = last_s2 ? peak_new : '0;
	end

	// frame start clears before this word counts, frame wrap clears after
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			peak_q <= '0;
		end else if (v_s2) begin
			peak_q <= wrap_s2 ? '0 : peak_new;
		end
	end

	// ---------------- output queue ----------------
	res_t             oq_q [OQ_DEPTH];
	logic [OQ_PW-1:0] oq_wr_q, oq_rd_q;
	logic [OQ_CW-1:0] oq_cnt_q;
	logic             oq_push, oq_pop;
	res_t             oq_head;

	assign oq_push = v_s2 && emit_s2;
	assign oq_pop  = m_tvalid && m_tready;
	assign oq_head = oq_q[oq_rd_q];

	// reserve a slot for every word still in the pipe
	assign s_tready = (32'(oq_cnt_q) + 32'(v_s1) + 32'(v_s2)) < 32'(OQ_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			oq_wr_q  <= '0;
			oq_rd_q  <= '0;
			oq_cnt_q <= '0;
		end else begin
			if (oq_push) oq_wr_q <= OQ_PW'(32'(oq_wr_q) + 32'd1);
			if (oq_pop)  oq_rd_q <= OQ_PW'(32'(oq_rd_q) + 32'd1);
			if (oq_push && !oq_pop)      oq_cnt_q <= oq_cnt_q + OQ_CW'(1);
			else if (!oq_push && oq_pop) oq_cnt_q <= oq_cnt_q - OQ_CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (oq_push) begin
			oq_q[oq_wr_q] <= res;
		end
	end

	assign m_tvalid = (oq_cnt_q != '0);
	assign m_tlast  = oq_head.last;
	assign m_tdata  = {4'b0, oq_head.peak, oq_head.col, oq_head.row, oq_head.pixel};

	// ---------------- checks ----------------
	a_oq_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		oq_push |-> (32'(oq_cnt_q) < 32'(OQ_DEPTH)) || oq_pop)
		else $error("output queue overflow");

	a_peak_only_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[35:28] == 8'd0)
		else $error("peak reported on a word that does not close the frame");

	a_row_interior: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[17:8] != 10'd0) && (m_tdata[27:18] != 10'd0))
		else $error("border position emitted");

	a_pipe_advance: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> v_s2 && fwd_v_q)
		else $error("word lost between line store and window");

	// rows above the first line carry unwritten taps, hence the case equality
	a_window_shift: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |=> col_l === $past(col_c))
		else $error("window column skipped in the cell row");

endmodule
